// ----- rtl/r0ss_pkg.sv -----
// Shared types and constants for the RAID0 stripe request splitter.
// Used by r0ss_divider and raid0_stripe_request_splitter; depends on nothing.
`default_nettype none

package r0ss_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int BLK_W    = 48;
    localparam int CNT_W    = 32;
    localparam int DISK_W   = 4;
    localparam int CFG_W    = 5;
    localparam int STRIP_W  = BLK_W + 1;   // last block may pass the 48-bit space
    localparam int MAX_SHIFT = 24;

    localparam int DEFAULT_MAX_DISKS = 16;

    // register indexes
    localparam logic REG_DISK_COUNT  = 1'b0;
    localparam logic REG_STRIP_SHIFT = 1'b1;

    localparam logic [CFG_W-1:0] DISK_COUNT_RESET  = 5'd1;
    localparam logic [CFG_W-1:0] STRIP_SHIFT_RESET = 5'd7;

    // request kinds
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_S_GO,
        ST_S_WAIT,
        ST_E_GO,
        ST_E_WAIT,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/r0ss_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses r0ss_pkg::div_status_t for its status outputs.
`default_nettype none

module r0ss_divider #(
    parameter int DIVIDEND_W = r0ss_pkg::STRIP_W,
    parameter int DIVISOR_W  = r0ss_pkg::CFG_W
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [DIVIDEND_W-1:0]       dividend,
    input  wire [DIVISOR_W-1:0]        divisor,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder,
    output r0ss_pkg::div_status_t      status
);

    localparam int ITER_W = $clog2(DIVIDEND_W + 1);

    logic [ITER_W-1:0]     iter_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  trial_ge;
    logic [DIVISOR_W:0]    trial_diff;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_ge   = (trial >= {1'b0, divisor});
        trial_diff = trial - {1'b0, divisor};
        rem_next   = trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            iter_reg <= ITER_W'(DIVIDEND_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit into the remainder, the quotient bit in at the bottom
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/raid0_stripe_request_splitter.sv -----
// Top level of the RAID0 stripe request splitter: sequencer and result formatting.
// Depends on r0ss_pkg and r0ss_divider.
//
// Usage: write disk_count (index 0) and strip_shift (index 1) through the cfg port
// while idle. A request transaction (operation, start_block, block_count) is taken
// when in_valid is high and in_stall is low. The block then holds in_stall high
// until every result of that request is delivered.
// Sequence: the start strip and the end strip are each divided by the disk count in
// one shared restoring divider at one quotient bit per cycle, start strip first, and
// a setup state then forms the first result. Results leave the output register
// at one per cycle while out_stall is low; a request has N results,
// N running from 1 to the disk count.
// A read or write gives one result; an unmap or flush gives one per involved disk,
// starting at the start disk and wrapping, with last set on the final one.
// When out_stall is high the result in the output register holds unchanged.
// Reset returns to idle, drops any request in flight and restores disk_count = 1
// and strip_shift = 7.
`default_nettype none

module raid0_stripe_request_splitter #(
    parameter int MAX_DISKS = r0ss_pkg::DEFAULT_MAX_DISKS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration
    input  wire                              cfg_we,
    input  wire                              cfg_index,
    input  wire [r0ss_pkg::CFG_W-1:0]        cfg_data,
    // request channel
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [r0ss_pkg::OP_W-1:0]         operation,
    input  wire [r0ss_pkg::BLK_W-1:0]        start_block,
    input  wire [r0ss_pkg::CNT_W-1:0]        block_count,
    // result channel
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [r0ss_pkg::DISK_W-1:0]      disk_index,
    output logic [r0ss_pkg::BLK_W-1:0]       disk_block,
    output logic [r0ss_pkg::CNT_W-1:0]       disk_block_count,
    output logic [r0ss_pkg::OP_W-1:0]        kind,
    output logic                             failed,
    output logic                             last
);

    localparam int CFG_W   = r0ss_pkg::CFG_W;
    localparam int BLK_W   = r0ss_pkg::BLK_W;
    localparam int CNT_W   = r0ss_pkg::CNT_W;
    localparam int STRIP_W = r0ss_pkg::STRIP_W;
    localparam int OFF_W   = r0ss_pkg::MAX_SHIFT;

    r0ss_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0] disk_count_reg, strip_shift_reg;

    // request context
    logic [r0ss_pkg::OP_W-1:0] op_reg;
    logic [BLK_W-1:0]          start_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CFG_W-1:0]          dc_reg;
    logic [CFG_W-1:0]          sh_reg;
    logic [STRIP_W-1:0]        last_blk_reg;
    logic [STRIP_W-1:0]        s_strip_reg, e_strip_reg;
    logic [STRIP_W-1:0]        s_q_reg, e_q_reg;
    logic [CFG_W-1:0]          s_r_reg, e_r_reg;
    logic [CFG_W-1:0]          disk_reg;
    logic [CFG_W-1:0]          remain_reg;

    // output registers
    logic [r0ss_pkg::DISK_W-1:0] disk_index_reg;
    logic [BLK_W-1:0]            disk_block_reg;
    logic [CNT_W-1:0]            disk_block_count_reg;
    logic                        failed_reg;
    logic                        last_reg;

    // divider
    logic                        div_start;
    logic [STRIP_W-1:0]          div_dividend;
    logic [STRIP_W-1:0]          div_quo;
    logic [CFG_W-1:0]            div_rem;
    r0ss_pkg::div_status_t       div_stat;

    logic in_accept, out_accept;
    logic [CFG_W-1:0] dc_sat, sh_sat;
    logic [CNT_W-1:0] count_fix;

    always_comb
    begin
        in_accept  = in_valid && !in_stall;
        out_accept = out_valid && !out_stall;

        if (disk_count_reg == '0)
            dc_sat = CFG_W'(1);
        else if (int'(disk_count_reg) > MAX_DISKS)
            dc_sat = CFG_W'(MAX_DISKS);
        else
            dc_sat = disk_count_reg;

        sh_sat    = (int'(strip_shift_reg) > r0ss_pkg::MAX_SHIFT)
                    ? CFG_W'(r0ss_pkg::MAX_SHIFT) : strip_shift_reg;
        count_fix = (block_count == '0) ? CNT_W'(1) : block_count;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg  <= r0ss_pkg::DISK_COUNT_RESET;
            strip_shift_reg <= r0ss_pkg::STRIP_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == r0ss_pkg::REG_DISK_COUNT)
                disk_count_reg <= cfg_data;
            else
                strip_shift_reg <= cfg_data;
        end
    end

    r0ss_divider #(
        .DIVIDEND_W (STRIP_W),
        .DIVISOR_W  (CFG_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (dc_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    // sub-request arithmetic for one disk, shared by setup and every emit step
    logic [OFF_W:0]      one_sh;
    logic [OFF_W-1:0]    off_mask, s_off, e_off, lo, hi;
    logic [CFG_W-1:0]    disk_step, disk_sel, cur_d;
    logic [STRIP_W-1:0]  first, final_strip, first_sh, strip_diff;
    logic [CNT_W-1:0]    span32;
    logic [BLK_W-1:0]    calc_blk;
    logic [CNT_W-1:0]    calc_cnt;
    logic                req_failed;
    logic [CFG_W-1:0]    n_results;

    always_comb
    begin
        one_sh   = (OFF_W+1)'(1) << sh_reg;
        off_mask = OFF_W'(one_sh - 1'b1);
        s_off    = start_reg[OFF_W-1:0] & off_mask;
        e_off    = last_blk_reg[OFF_W-1:0] & off_mask;

        // advance disk with wrap at the disk count
        disk_step = (disk_reg + 1'b1 == dc_reg) ? '0 : disk_reg + 1'b1;
        disk_sel  = (state_reg == r0ss_pkg::ST_SETUP) ? s_r_reg : disk_step;
        cur_d     = disk_sel;

        first       = s_q_reg + STRIP_W'(cur_d < s_r_reg);
        final_strip = e_q_reg - STRIP_W'(cur_d > e_r_reg);
        lo          = (cur_d == s_r_reg) ? s_off : '0;
        hi          = (cur_d == e_r_reg) ? e_off : off_mask;

        first_sh = first << sh_reg;
        calc_blk = first_sh[BLK_W-1:0] + BLK_W'(lo);
        span32   = CNT_W'(final_strip - first);
        calc_cnt = (span32 << sh_reg) + CNT_W'(hi) - CNT_W'(lo) + CNT_W'(1);

        req_failed = ((op_reg == r0ss_pkg::OP_READ) || (op_reg == r0ss_pkg::OP_WRITE))
                     && (s_strip_reg != e_strip_reg) && (dc_reg > CFG_W'(1));
        strip_diff = e_strip_reg - s_strip_reg;
        n_results  = (strip_diff >= STRIP_W'(dc_reg)) ? dc_reg
                                                       : CFG_W'(strip_diff) + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            r0ss_pkg::ST_IDLE:   if (in_accept) state_next = r0ss_pkg::ST_LOAD;
            r0ss_pkg::ST_LOAD:   state_next = r0ss_pkg::ST_S_GO;
            r0ss_pkg::ST_S_GO:   state_next = r0ss_pkg::ST_S_WAIT;
            r0ss_pkg::ST_S_WAIT: if (div_stat.done) state_next = r0ss_pkg::ST_E_GO;
            r0ss_pkg::ST_E_GO:   state_next = r0ss_pkg::ST_E_WAIT;
            r0ss_pkg::ST_E_WAIT: if (div_stat.done) state_next = r0ss_pkg::ST_SETUP;
            r0ss_pkg::ST_SETUP:  state_next = r0ss_pkg::ST_EMIT;
            r0ss_pkg::ST_EMIT:
                if (out_accept && remain_reg == CFG_W'(1))
                    state_next = r0ss_pkg::ST_IDLE;
            default:             state_next = r0ss_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        div_start    = 1'b0;
        div_dividend = s_strip_reg;
        case (state_reg)
            r0ss_pkg::ST_IDLE:  in_stall = 1'b0;
            r0ss_pkg::ST_S_GO:  div_start = 1'b1;
            r0ss_pkg::ST_E_GO:
            begin
                div_start    = 1'b1;
                div_dividend = e_strip_reg;
            end
            r0ss_pkg::ST_EMIT:  out_valid = 1'b1;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= r0ss_pkg::ST_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == r0ss_pkg::ST_SETUP)
                remain_reg <= req_failed ? CFG_W'(1) : n_results;
            else if (out_accept)
                remain_reg <= remain_reg - 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= operation;
            start_reg <= start_block;
            count_reg <= count_fix;
            dc_reg    <= dc_sat;
            sh_reg    <= sh_sat;
        end

        if (state_reg == r0ss_pkg::ST_LOAD)
        begin
            last_blk_reg <= STRIP_W'(start_reg) + STRIP_W'(count_reg) - 1'b1;
            s_strip_reg  <= STRIP_W'(start_reg) >> sh_reg;
            e_strip_reg  <= (STRIP_W'(start_reg) + STRIP_W'(count_reg) - 1'b1) >> sh_reg;
        end

        if (state_reg == r0ss_pkg::ST_S_WAIT && div_stat.done)
        begin
            s_q_reg <= div_quo;
            s_r_reg <= div_rem;
        end

        if (state_reg == r0ss_pkg::ST_E_WAIT && div_stat.done)
        begin
            e_q_reg <= div_quo;
            e_r_reg <= div_rem;
        end

        if (state_reg == r0ss_pkg::ST_SETUP)
        begin
            disk_reg   <= disk_sel;
            failed_reg <= req_failed;
            if (req_failed)
            begin
                disk_index_reg       <= '0;
                disk_block_reg       <= '0;
                disk_block_count_reg <= '0;
                last_reg             <= 1'b1;
            end
            else
            begin
                disk_index_reg       <= disk_sel[r0ss_pkg::DISK_W-1:0];
                disk_block_reg       <= calc_blk;
                disk_block_count_reg <= calc_cnt;
                last_reg             <= (n_results == CFG_W'(1));
            end
        end
        else if (out_accept && remain_reg != CFG_W'(1))
        begin
            // advance to the next disk of this request
            disk_reg             <= disk_sel;
            disk_index_reg       <= disk_sel[r0ss_pkg::DISK_W-1:0];
            disk_block_reg       <= calc_blk;
            disk_block_count_reg <= calc_cnt;
            last_reg             <= (remain_reg == CFG_W'(2));
        end
    end

    assign disk_index       = disk_index_reg;
    assign disk_block       = disk_block_reg;
    assign disk_block_count = disk_block_count_reg;
    assign kind             = op_reg;
    assign failed           = failed_reg;
    assign last             = last_reg;

    // checks
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!out_valid && !div_stat.busy))
        else $error("request taken while work is in flight");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == r0ss_pkg::ST_S_WAIT ||
                           state_reg == r0ss_pkg::ST_E_WAIT))
        else $error("divider finished outside a wait state");

    a_failed_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> (last && remain_reg == CFG_W'(1)))
        else $error("failed result is not the only result");

    a_disk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !failed) |-> (disk_reg < dc_reg))
        else $error("disk index beyond disk count");

    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (remain_reg == CFG_W'(1))))
        else $error("last flag out of step with remaining count");

endmodule

`default_nettype wire
